// File: hw/rtl/bhpc_pkg.sv
package bhpc_pkg;

  localparam int unsigned NODES  = 4096;
  localparam int unsigned PLANES = 4096;

  localparam int unsigned NodeAw  = $clog2(NODES);
  localparam int unsigned PlaneAw = $clog2(PLANES);
  localparam int unsigned StepW   = $clog2(NODES) + 1;

  localparam int unsigned IdxW   = 12;
  localparam int unsigned ChildW = 13;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CoordW = 32;
  localparam int unsigned NormW  = 18;
  localparam int unsigned ContW  = 5;
  localparam int unsigned ProdW  = NormW + CoordW;
  localparam int unsigned AccW   = ProdW + 3;

  localparam int unsigned NodeW   = IdxW + 2 * ChildW;
  localparam int unsigned NormsW  = 3 * NormW;
  localparam int unsigned OffsW   = CoordW + KindW;

  localparam int unsigned SDataW = 184;
  localparam int unsigned MDataW = 8;

  localparam logic signed [NormW-1:0] NormMax = 18'sd131071;
  localparam logic signed [NormW-1:0] NormMin = -18'sd131072;

  localparam logic signed [ContW-1:0] WaterCode = -5'sd3;
  localparam logic signed [ContW-1:0] CurrentHi = -5'sd9;
  localparam logic signed [ContW-1:0] CurrentLo = -5'sd14;
  localparam logic signed [ChildW-1:0] DeepCode = -13'sd16;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_NODE  = 2'd1,
    CMD_PLANE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE,
    ST_PLANE,
    ST_DIST,
    ST_WAIT,
    ST_EMIT
  } walk_state_e;

  typedef enum logic {
    D_IDLE,
    D_MUL
  } dist_state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } point_t;

  typedef struct packed {
    logic        [KindW-1:0]  kind;
    logic signed [CoordW-1:0] offset;
    logic signed [NormW-1:0]  nz;
    logic signed [NormW-1:0]  ny;
    logic signed [NormW-1:0]  nx;
  } plane_t;

  typedef struct packed {
    logic done;
    logic back;
  } dist_status_t;

  function automatic logic signed [NormW-1:0] sat_normal(logic signed [CoordW-1:0] v);
    logic signed [NormW-1:0] r;
    if (v > CoordW'(signed'(NormMax))) begin
      r = NormMax;
    end else if (v < CoordW'(signed'(NormMin))) begin
      r = NormMin;
    end else begin
      r = v[NormW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ContW-1:0] map_contents(logic signed [ChildW-1:0] code,
                                                           logic fold);
    logic signed [ContW-1:0] c;
    if (code < DeepCode) begin
      c = DeepCode[ContW-1:0];
    end else begin
      c = code[ContW-1:0];
    end
    if (fold && (c <= CurrentHi) && (c >= CurrentLo)) begin
      c = WaterCode;
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/bhpc_ram.sv
module bhpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bhpc_dist.sv
module bhpc_dist (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  bhpc_pkg::plane_t        plane_i,
  input  bhpc_pkg::point_t        point_i,
  output bhpc_pkg::dist_status_t  status_o
);

  bhpc_pkg::dist_state_e state_q, state_d;
  logic [1:0] k_q, k_d;
  logic signed [bhpc_pkg::ProdW-1:0] prod_q;
  logic signed [bhpc_pkg::AccW-1:0]  acc_q;
  logic done_q, back_q;

  logic signed [bhpc_pkg::NormW-1:0]  n_sel;
  logic signed [bhpc_pkg::CoordW-1:0] p_sel;
  logic signed [bhpc_pkg::CoordW:0]   axial_diff;
  logic signed [bhpc_pkg::AccW-1:0]   acc_sum;
  logic signed [bhpc_pkg::AccW-1:0]   off_scaled;
  logic signed [bhpc_pkg::CoordW-1:0] p_axial;

  always_comb begin
    case (k_q)
      2'd0:    begin n_sel = plane_i.nx; p_sel = point_i.x; end
      2'd1:    begin n_sel = plane_i.ny; p_sel = point_i.y; end
      2'd2:    begin n_sel = plane_i.nz; p_sel = point_i.z; end
      default: begin n_sel = '0;         p_sel = '0;        end
    endcase
  end

  always_comb begin
    case (plane_i.kind[1:0])
      2'd0:    p_axial = point_i.x;
      2'd1:    p_axial = point_i.y;
      default: p_axial = point_i.z;
    endcase
  end

  assign axial_diff = {p_axial[bhpc_pkg::CoordW-1], p_axial}
                    - {plane_i.offset[bhpc_pkg::CoordW-1], plane_i.offset};
  assign off_scaled = {{(bhpc_pkg::AccW - bhpc_pkg::CoordW - 16){plane_i.offset[31]}},
                       plane_i.offset, 16'b0};
  assign acc_sum    = acc_q + bhpc_pkg::AccW'(prod_q);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      bhpc_pkg::D_IDLE: begin
        if (start_i && (plane_i.kind >= bhpc_pkg::KindW'(3))) begin
          state_d = bhpc_pkg::D_MUL;
          k_d     = 2'd0;
        end
      end
      bhpc_pkg::D_MUL: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = bhpc_pkg::D_IDLE;
        end
      end
      default: state_d = bhpc_pkg::D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhpc_pkg::D_IDLE;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      done_q  <= (state_q == bhpc_pkg::D_IDLE && start_i &&
                  plane_i.kind < bhpc_pkg::KindW'(3)) ||
                 (state_q == bhpc_pkg::D_MUL && k_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bhpc_pkg::D_IDLE && start_i) begin
      back_q <= axial_diff[bhpc_pkg::CoordW];
      acc_q  <= -off_scaled;
    end
    if (state_q == bhpc_pkg::D_MUL) begin
      prod_q <= n_sel * p_sel;
      if (k_q != 2'd0) begin
        acc_q <= acc_sum;
      end
      if (k_q == 2'd3) begin
        back_q <= acc_sum[bhpc_pkg::AccW-1];
      end
    end
  end

  assign status_o.done = done_q;
  assign status_o.back = back_q;

endmodule

// File: hw/rtl/bsp_hull_point_classifier_core.sv
// BSP clip-hull point classifier.
// Slave stream carries requests; s_axis_tuser selects query (0), node write
// (1) or plane write (2); 3 is dropped. Writes load the node and plane
// tables and produce no result. A query walks the tree from the given start
// node and returns one result on the master stream: contents code in
// m_axis_tdata, walk-limit flag in m_axis_tuser.
// Write requests complete while the block stays idle. For a query, the time
// per visited node is set by the node and plane memory reads and, for a
// general plane, by the single shared multiplier that forms the three normal
// products in turn; an axial plane needs no multiply.
// s_axis_tready is low while a query walks. A finished result sits in the
// output register; the next request is taken while it waits. If the receiver
// stalls and a second query finishes, that walk holds until the output frees.
// cfg_we_i writes fold_currents; write it only while the block is idle.
// Reset clears control state and fold_currents; table contents are
// undefined until written.
module bsp_hull_point_classifier_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // index, plane_ref, child_front, child_back, plane_kind,
  // coord_x, coord_y, coord_z, plane_offset
  input  logic [bhpc_pkg::SDataW-1:0]     s_axis_tdata,
  // cmd
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // contents
  output logic [bhpc_pkg::MDataW-1:0]     m_axis_tdata,
  // walk_limit_hit
  output logic [0:0]                      m_axis_tuser
);

  logic [bhpc_pkg::IdxW-1:0]           in_index, in_pref;
  logic signed [bhpc_pkg::ChildW-1:0]  in_front, in_back;
  logic [bhpc_pkg::KindW-1:0]          in_kind;
  logic signed [bhpc_pkg::CoordW-1:0]  in_x, in_y, in_z, in_off;
  bhpc_pkg::cmd_e                      in_cmd;

  assign in_index = s_axis_tdata[11:0];
  assign in_pref  = s_axis_tdata[23:12];
  assign in_front = s_axis_tdata[36:24];
  assign in_back  = s_axis_tdata[49:37];
  assign in_kind  = s_axis_tdata[52:50];
  assign in_x     = s_axis_tdata[84:53];
  assign in_y     = s_axis_tdata[116:85];
  assign in_z     = s_axis_tdata[148:117];
  assign in_off   = s_axis_tdata[180:149];
  assign in_cmd   = bhpc_pkg::cmd_e'(s_axis_tuser);

  bhpc_pkg::walk_state_e state_q, state_d;
  logic                                fold_q;
  logic signed [bhpc_pkg::ChildW-1:0]  cur_q;
  logic [bhpc_pkg::StepW-1:0]          steps_q;
  bhpc_pkg::point_t                    pt_q;
  logic signed [bhpc_pkg::ContW-1:0]   res_q;
  logic                                lim_q;
  logic                                m_valid_q;
  logic signed [bhpc_pkg::ContW-1:0]   m_cont_q;
  logic                                m_lim_q;

  logic accept;
  assign s_axis_tready = (state_q == bhpc_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [bhpc_pkg::NodeW-1:0]  node_rdata;
  logic [bhpc_pkg::NormsW-1:0] norms_rdata;
  logic [bhpc_pkg::OffsW-1:0]  offs_rdata;
  logic [bhpc_pkg::NormsW-1:0] norms_wdata;

  logic [bhpc_pkg::IdxW-1:0]           nd_pref;
  logic signed [bhpc_pkg::ChildW-1:0]  nd_front, nd_back;
  assign nd_pref  = node_rdata[11:0];
  assign nd_front = node_rdata[24:12];
  assign nd_back  = node_rdata[37:25];

  assign norms_wdata = {bhpc_pkg::sat_normal(in_z), bhpc_pkg::sat_normal(in_y),
                        bhpc_pkg::sat_normal(in_x)};

  bhpc_ram #(.Width(bhpc_pkg::NodeW), .Depth(bhpc_pkg::NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (accept && in_cmd == bhpc_pkg::CMD_NODE),
    .waddr_i (in_index[bhpc_pkg::NodeAw-1:0]),
    .wdata_i ({in_back, in_front, in_pref}),
    .re_i    (state_q == bhpc_pkg::ST_NODE),
    .raddr_i (cur_q[bhpc_pkg::NodeAw-1:0]),
    .rdata_o (node_rdata)
  );

  bhpc_ram #(.Width(bhpc_pkg::NormsW), .Depth(bhpc_pkg::PLANES)) u_norm_ram (
    .clk_i   (clk_i),
    .we_i    (accept && in_cmd == bhpc_pkg::CMD_PLANE),
    .waddr_i (in_index[bhpc_pkg::PlaneAw-1:0]),
    .wdata_i (norms_wdata),
    .re_i    (state_q == bhpc_pkg::ST_PLANE),
    .raddr_i (nd_pref[bhpc_pkg::PlaneAw-1:0]),
    .rdata_o (norms_rdata)
  );

  bhpc_ram #(.Width(bhpc_pkg::OffsW), .Depth(bhpc_pkg::PLANES)) u_offs_ram (
    .clk_i   (clk_i),
    .we_i    (accept && in_cmd == bhpc_pkg::CMD_PLANE),
    .waddr_i (in_index[bhpc_pkg::PlaneAw-1:0]),
    .wdata_i ({in_kind, in_off}),
    .re_i    (state_q == bhpc_pkg::ST_PLANE),
    .raddr_i (nd_pref[bhpc_pkg::PlaneAw-1:0]),
    .rdata_o (offs_rdata)
  );

  bhpc_pkg::plane_t       plane;
  bhpc_pkg::dist_status_t dist_st;

  assign plane = {offs_rdata, norms_rdata};

  bhpc_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == bhpc_pkg::ST_DIST),
    .plane_i  (plane),
    .point_i  (pt_q),
    .status_o (dist_st)
  );

  logic signed [bhpc_pkg::ChildW-1:0] next_node;
  logic [bhpc_pkg::StepW-1:0]         steps_inc;
  logic                               at_leaf, at_limit, out_free;

  assign next_node = dist_st.back ? nd_back : nd_front;
  assign steps_inc = steps_q + bhpc_pkg::StepW'(1);
  assign at_leaf   = next_node[bhpc_pkg::ChildW-1];
  assign at_limit  = (steps_inc == bhpc_pkg::StepW'(bhpc_pkg::NODES));
  assign out_free  = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bhpc_pkg::ST_IDLE: begin
        if (accept && in_cmd == bhpc_pkg::CMD_QUERY) begin
          state_d = bhpc_pkg::ST_NODE;
        end
      end
      bhpc_pkg::ST_NODE:  state_d = bhpc_pkg::ST_PLANE;
      bhpc_pkg::ST_PLANE: state_d = bhpc_pkg::ST_DIST;
      bhpc_pkg::ST_DIST:  state_d = bhpc_pkg::ST_WAIT;
      bhpc_pkg::ST_WAIT: begin
        if (dist_st.done) begin
          state_d = (at_leaf || at_limit) ? bhpc_pkg::ST_EMIT : bhpc_pkg::ST_NODE;
        end
      end
      bhpc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = bhpc_pkg::ST_IDLE;
        end
      end
      default: state_d = bhpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bhpc_pkg::ST_IDLE;
      fold_q    <= 1'b0;
      cur_q     <= '0;
      steps_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        fold_q <= cfg_wdata_i;
      end
      if (accept && in_cmd == bhpc_pkg::CMD_QUERY) begin
        cur_q   <= {1'b0, in_index};
        steps_q <= '0;
      end
      if (state_q == bhpc_pkg::ST_WAIT && dist_st.done) begin
        cur_q   <= next_node;
        steps_q <= steps_inc;
      end
      if (state_q == bhpc_pkg::ST_EMIT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_cmd == bhpc_pkg::CMD_QUERY) begin
      pt_q <= {in_z, in_y, in_x};
    end
    if (state_q == bhpc_pkg::ST_WAIT && dist_st.done) begin
      if (at_leaf) begin
        res_q <= bhpc_pkg::map_contents(next_node, fold_q);
        lim_q <= 1'b0;
      end else begin
        res_q <= '0;
        lim_q <= 1'b1;
      end
    end
    if (state_q == bhpc_pkg::ST_EMIT && out_free) begin
      m_cont_q <= res_q;
      m_lim_q  <= lim_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = {{(bhpc_pkg::MDataW - bhpc_pkg::ContW){1'b0}}, m_cont_q};
  assign m_axis_tuser[0] = m_lim_q;

endmodule
